[hw/rtl/tpba_pkg.sv]
`default_nettype none

package tpba_pkg;

  // Request type codes
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_SLOW_BASE  = 3'd0;
  localparam logic [2:0] CFG_FAST_BASE  = 3'd1;
  localparam logic [2:0] CFG_SLOW_LIMIT = 3'd2;
  localparam logic [2:0] CFG_FAST_LIMIT = 3'd3;
  localparam logic [2:0] CFG_FAST_QEND  = 3'd4;

  // Configuration reset values
  localparam logic [31:0] RST_SLOW_BASE  = 32'h0200_0000;
  localparam logic [31:0] RST_FAST_BASE  = 32'h0300_0000;
  localparam logic [31:0] RST_SLOW_LIMIT = 32'h0204_0000;
  localparam logic [31:0] RST_FAST_LIMIT = 32'h0300_7800;
  localparam logic [31:0] RST_FAST_QEND  = 32'h0300_7800;

  // Field widths
  localparam int ADDR_W      = 32;
  localparam int SIZE_W      = 24;
  localparam int RSIZE_W     = SIZE_W + 1;
  localparam int SLOT_IN_W   = 6;
  localparam int SLOT_IN_N   = 1 << SLOT_IN_W;

  // One result transaction
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              failed;
    logic              from_fast;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/two_pool_bump_allocator.sv]
`default_nettype none

// Channel   Handshake             Payload
// in        in_valid / in_ready   req_type, prefer_slow, use_slot, slot_index, request_bytes
// out       out_valid / out_ready address, failed, from_fast
// cfg       cfg_write             cfg_index, cfg_data
//
// Each transaction reads the slot entry from the slot memory on accept,
// then in the execute state computes, writes back the entry and cursor, and
// loads the result. The next request is taken while a result waits; it then
// holds in the execute state until the output register frees. Reset restores
// the configuration, puts the cursors at their bases and clears the slot valid bits.
module two_pool_bump_allocator #(
  parameter int SLOT_COUNT = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     req_type,
  input  wire logic                           prefer_slow,
  input  wire logic                           use_slot,
  input  wire logic [tpba_pkg::SLOT_IN_W-1:0] slot_index,
  input  wire logic [tpba_pkg::SIZE_W-1:0]    request_bytes,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [tpba_pkg::ADDR_W-1:0]         address,
  output logic                                failed,
  output logic                                from_fast,
  input  wire logic                           cfg_write,
  input  wire logic [2:0]                     cfg_index,
  input  wire logic [tpba_pkg::ADDR_W-1:0]    cfg_data
);
  import tpba_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam logic [IDX_W-1:0] IDX_SLOW = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_FAST = IDX_W'(1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;

  logic [ADDR_W-1:0] slow_base, fast_base, slow_limit, fast_limit, fast_qend;
  logic [ADDR_W-1:0] slow_cur, fast_cur;

  logic [1:0]         r_type;
  logic               r_slow;
  logic               r_named;
  logic [IDX_W-1:0]   r_idx;
  logic [RSIZE_W-1:0] r_size;

  logic [IDX_W-1:0]  idx_map [SLOT_IN_N];
  logic              accept, fire;
  logic [ADDR_W-1:0] mem_rdata, slot_val, alloc_addr;
  logic [ADDR_W:0]   slow_end, fast_end;
  logic              slow_fit, fast_fit, pool_ok, take_fast, reuse;
  logic              mem_wr_en;
  result_t           res_next, res;

  // Map the input slot number onto the table depth
  for (genvar i = 0; i < SLOT_IN_N; i++) begin : g_idx
    assign idx_map[i] = IDX_W'(i % SLOT_COUNT);
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fire     = (state == S_EXEC) && (!out_valid || out_ready);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slow_base  <= RST_SLOW_BASE;
      fast_base  <= RST_FAST_BASE;
      slow_limit <= RST_SLOW_LIMIT;
      fast_limit <= RST_FAST_LIMIT;
      fast_qend  <= RST_FAST_QEND;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SLOW_BASE:  slow_base  <= cfg_data;
        CFG_FAST_BASE:  fast_base  <= cfg_data;
        CFG_SLOW_LIMIT: slow_limit <= cfg_data;
        CFG_FAST_LIMIT: fast_limit <= cfg_data;
        CFG_FAST_QEND:  fast_qend  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the request, rounding the size up to a multiple of four
  always_ff @(posedge clk) begin
    if (accept) begin
      r_type  <= req_type;
      r_slow  <= prefer_slow;
      r_named <= use_slot;
      r_idx   <= idx_map[slot_index];
      r_size  <= (RSIZE_W'(request_bytes) + RSIZE_W'(3)) & ~RSIZE_W'(3);
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (accept) state <= S_EXEC;
        S_EXEC:  if (fire) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  tpba_slot_mem #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_slot_mem (
    .clk     (clk),
    .rst     (rst),
    .clr     (fire && (r_type == REQ_CLEAR)),
    .rd_en   (accept),
    .rd_addr (idx_map[slot_index]),
    .rd_data (mem_rdata),
    .wr_en   (mem_wr_en),
    .wr_addr (r_idx),
    .wr_data (alloc_addr)
  );

  // Fit check on both pools in parallel
  assign slow_end = {1'b0, slow_cur} + (ADDR_W + 1)'(r_size);
  assign fast_end = {1'b0, fast_cur} + (ADDR_W + 1)'(r_size);
  assign slow_fit = slow_end < {1'b0, slow_limit};
  assign fast_fit = fast_end < {1'b0, fast_limit};
  assign pool_ok  = slow_fit || fast_fit;
  assign take_fast = r_slow ? (!slow_fit && fast_fit) : fast_fit;
  assign alloc_addr = take_fast ? fast_cur : slow_cur;

  // Slots 0 and 1 are the cursors themselves
  always_comb begin
    if (r_idx == IDX_SLOW) begin
      slot_val = slow_cur;
    end else if (r_idx == IDX_FAST) begin
      slot_val = fast_cur;
    end else begin
      slot_val = mem_rdata;
    end
  end

  assign reuse = r_named && (slot_val != '0);
  assign mem_wr_en = fire && (r_type == REQ_ALLOC) && !reuse && pool_ok && r_named &&
                     (r_idx != IDX_SLOW) && (r_idx != IDX_FAST);

  // Result of the current transaction
  always_comb begin
    res_next = '0;
    unique case (r_type)
      REQ_QUERY: res_next.address = r_slow ? (slow_limit - slow_cur) : (fast_qend - fast_cur);
      REQ_ALLOC: begin
        if (reuse) begin
          res_next.address = slot_val;
        end else if (pool_ok) begin
          res_next.address   = alloc_addr;
          res_next.from_fast = take_fast;
        end else begin
          res_next.failed = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Clear or advance cursors; a named cursor slot is overwritten after the advance
  always_ff @(posedge clk) begin
    if (rst) begin
      slow_cur <= RST_SLOW_BASE;
      fast_cur <= RST_FAST_BASE;
    end else if (fire) begin
      if (r_type == REQ_CLEAR) begin
        slow_cur <= slow_base;
        fast_cur <= fast_base;
      end else if ((r_type == REQ_ALLOC) && !reuse && pool_ok) begin
        if (take_fast) begin
          fast_cur <= fast_end[ADDR_W-1:0];
        end else begin
          slow_cur <= slow_end[ADDR_W-1:0];
        end
        if (r_named && (r_idx == IDX_SLOW)) begin
          slow_cur <= alloc_addr;
        end
        if (r_named && (r_idx == IDX_FAST)) begin
          fast_cur <= alloc_addr;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign address   = res.address;
  assign failed    = res.failed;
  assign from_fast = res.from_fast;

  // Checks
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && failed |-> (address == '0) && !from_fast)
    else $error("failed result carries an address or pool flag");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_wr_en && accept))
    else $error("slot memory read and write in the same cycle");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EXEC))
    else $error("result loaded outside the execute cycle");

endmodule

`default_nettype wire

[hw/rtl/tpba_slot_mem.sv]
`default_nettype none

module tpba_slot_mem #(
  parameter int SLOT_COUNT = 64,
  parameter int IDX_W      = $clog2(SLOT_COUNT)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       clr,
  input  wire logic                       rd_en,
  input  wire logic [IDX_W-1:0]           rd_addr,
  output logic [tpba_pkg::ADDR_W-1:0]     rd_data,
  input  wire logic                       wr_en,
  input  wire logic [IDX_W-1:0]           wr_addr,
  input  wire logic [tpba_pkg::ADDR_W-1:0] wr_data
);
  import tpba_pkg::*;

  logic [ADDR_W-1:0]     mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid;
  logic [ADDR_W-1:0]     rd_q;
  logic                  rd_valid;

  // Slot storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Per-entry valid bits, cleared at once by reset or a clear transaction
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (rd_en) begin
      rd_valid <= valid[rd_addr];
    end
  end

  // An entry never written since the last clear reads as zero
  assign rd_data = rd_valid ? rd_q : '0;

endmodule

`default_nettype wire
